[hw/rtl/lscpd_pkg.sv]
// lscpd_pkg: shared constants and types for the line sensor
// centroid pid drive block
// no dependencies
`timescale 1ns / 1ps
package lscpd_pkg;

  localparam int SensorCount = 8;
  localparam int SampleBits  = 12;
  localparam int DutyBits    = 10;
  localparam int PosBits     = 11;
  localparam int DriveBits   = 10;
  localparam int IntBits     = 15;
  localparam int NormBits    = 10;
  localparam int QuotBits    = 10;

  localparam logic [SampleBits-1:0] FullScale = {SampleBits{1'b1}};
  localparam int NormScale  = 1000;
  localparam int FloorLevel = 50;
  localparam int PosLimit   = 896;
  localparam int IntLimit   = 12800;
  localparam int DriveLimit = 400;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_CAL   = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2,
    REG_BASE   = 2'd3
  } reg_idx_t;

  // lane command and status between top level and lanes
  typedef struct packed {
    logic start;
    logic clear;
    logic cal;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_sts_t;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [NormBits-1:0]   norm_t;

endpackage

[hw/rtl/lscpd_lane.sv]
// lscpd_lane: one sensor lane, holds the calibration span and normalises
// a sample with a restoring divider, one quotient bit per cycle
// depends on lscpd_pkg
`timescale 1ns / 1ps
module lscpd_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lscpd_pkg::lane_cmd_t cmd,
  input  lscpd_pkg::sample_t   sample,
  output lscpd_pkg::lane_sts_t sts,
  output lscpd_pkg::norm_t     norm
);

  localparam int NumBits = lscpd_pkg::SampleBits + 10;
  localparam int CntBits = $clog2(lscpd_pkg::QuotBits + 1);

  lscpd_pkg::sample_t dark_r, light_r;
  logic [lscpd_pkg::SampleBits:0]  den_r;
  logic [NumBits-1:0]              num_r;
  logic [lscpd_pkg::SampleBits:0]  rem_r;
  logic [lscpd_pkg::QuotBits-1:0]  quo_r;
  logic [CntBits-1:0]              cnt_r;
  logic                            busy_r, done_r;
  lscpd_pkg::norm_t                norm_r;

  logic [lscpd_pkg::SampleBits:0]   hi, span, sc;
  logic [NumBits-1:0]               prod;
  logic [lscpd_pkg::SampleBits+1:0] trial;
  logic [lscpd_pkg::SampleBits:0]   rem_sh;
  logic                             qbit;

  // span set up: span at least one, sample clamped into it
  always_comb begin
    hi = (dark_r <= light_r) ? ({1'b0, light_r} + 1'b1) : {1'b0, dark_r};
    span = hi - {1'b0, light_r};
    if ({1'b0, sample} < {1'b0, light_r}) sc = '0;
    else if ({1'b0, sample} > hi) sc = span;
    else sc = {1'b0, sample} - {1'b0, light_r};
    prod = NumBits'(sc) * NumBits'(lscpd_pkg::NormScale);
  end

  // one restoring division step; quotient never exceeds 1000
  always_comb begin
    rem_sh = {rem_r[lscpd_pkg::SampleBits-1:0], num_r[NumBits-1]};
    trial  = {rem_r[lscpd_pkg::SampleBits], rem_sh} - {1'b0, den_r};
    qbit   = ~trial[lscpd_pkg::SampleBits+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_r  <= '0;
      light_r <= lscpd_pkg::FullScale;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.clear) begin
        dark_r  <= '0;
        light_r <= lscpd_pkg::FullScale;
      end else if (cmd.cal) begin
        if (sample > dark_r)  dark_r  <= sample;
        if (sample < light_r) light_r <= sample;
      end
      if (cmd.start) begin
        // skip the top numerator bits that cannot give a quotient bit
        num_r  <= prod << (NumBits - lscpd_pkg::QuotBits);
        rem_r  <= {1'b0, prod[NumBits-1:lscpd_pkg::QuotBits]};
        den_r  <= span;
        quo_r  <= '0;
        cnt_r  <= CntBits'(lscpd_pkg::QuotBits);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= qbit ? trial[lscpd_pkg::SampleBits:0] : rem_sh;
        quo_r <= {quo_r[lscpd_pkg::QuotBits-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntBits'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (done_r) begin
        norm_r <= (quo_r < lscpd_pkg::QuotBits'(lscpd_pkg::FloorLevel)) ? '0 : quo_r;
      end
    end
  end

  assign sts  = '{busy: busy_r, done: done_r};
  assign norm = norm_r;

endmodule

[hw/rtl/lscpd_div.sv]
// lscpd_div: signed restoring divider for the centroid, one bit per cycle,
// quotient truncated toward zero
// depends on lscpd_pkg
`timescale 1ns / 1ps
module lscpd_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [23:0]  num_in,
  input  logic         num_neg,
  input  logic [13:0]  den_in,
  output logic         done,
  output logic [23:0]  quo
);

  logic [23:0] num_r, quo_r;
  logic [14:0] rem_r;
  logic [13:0] den_r;
  logic [4:0]  cnt_r;
  logic        neg_r, busy_r, done_r;
  logic [14:0] rem_sh;
  logic [15:0] trial;

  always_comb begin
    rem_sh = {rem_r[13:0], num_r[23]};
    trial  = {1'b0, rem_sh} - {2'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= num_in;
        den_r  <= den_in;
        neg_r  <= num_neg;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= 5'd24;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= trial[15] ? rem_sh : trial[14:0];
        quo_r <= {quo_r[22:0], ~trial[15]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
      if (done_r && neg_r) quo_r <= ~quo_r + 1'b1;
    end
  end

  // quo is the signed result the cycle after done
  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hw/rtl/line_sensor_centroid_pid_drive_unit.sv]
// line_sensor_centroid_pid_drive_unit: top level, lanes, centroid merge,
// pid sequencer and output register
// depends on lscpd_pkg, lscpd_lane, lscpd_div
//
// usage
//   in_ channel: tdata = samples 0..7 (12 bits each), tuser = mode.
//   mode clear and mode calibrate update the per-sensor span and give no
//   item, so they can follow back to back; mode control step gives one
//   out_ item; mode three is dropped.
//   cfg_ channel: index 0 gain_p, 1 gain_i, 2 gain_d, 3 base_speed;
//   always ready, write only while idle.
//   a control step runs from acceptance to out_tvalid through the eight
//   lane dividers working in parallel and the sum, the centroid divider,
//   then position, three multiplies, drive and output. a lost line skips
//   the divider. one item in flight at a time; in_tready is low while a
//   step runs or a result waits, so a new control step is taken only once
//   the last result has gone.
//   reset clears calibration to min full scale and max zero, clears the
//   integral and previous position and loads the register defaults.
//   when the receiver stalls the result holds in out_tdata and no new
//   item is taken until it goes.
`timescale 1ns / 1ps
module line_sensor_centroid_pid_drive_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // sample_0 .. sample_7, 12 bits each
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_speed, right_speed, position, drive, line_lost, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N = lscpd_pkg::SensorCount;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_SUM, ST_DIV, ST_DIVW, ST_POS,
    ST_MP, ST_MI, ST_MD, ST_DRV, ST_OUT
  } state_t;

  state_t state_r;
  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [lscpd_pkg::DutyBits-1:0] base_r;
  logic signed [10:0] prev_r, pos_r;
  logic signed [11:0] deriv_r;
  logic signed [14:0] integ_r;
  logic signed [35:0] acc_r;
  logic signed [9:0]  drive_r;
  logic               lost_r, out_valid_r;
  logic [47:0]        out_data_r;
  logic signed [17:0] wsum_r;
  logic [13:0]        vsum_r;

  lscpd_pkg::lane_cmd_t cmd;
  lscpd_pkg::lane_sts_t sts [N];
  lscpd_pkg::norm_t     norm [N];
  logic                 acc_in;
  lscpd_pkg::mode_t     mode;

  assign mode      = lscpd_pkg::mode_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign acc_in    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    cmd.clear = acc_in && (mode == lscpd_pkg::MODE_CLEAR);
    cmd.cal   = acc_in && (mode == lscpd_pkg::MODE_CAL);
    cmd.start = acc_in && (mode == lscpd_pkg::MODE_STEP);
  end

  // sensor lanes
  for (genvar g = 0; g < N; g++) begin : g_lane
    lscpd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .sample (in_tdata[g*lscpd_pkg::SampleBits +: lscpd_pkg::SampleBits]),
      .sts    (sts[g]),
      .norm   (norm[g])
    );
  end

  // merge: weighted sum with weights 2i-7 and plain sum
  logic signed [17:0] wsum_c;
  logic [13:0]        vsum_c;
  always_comb begin
    wsum_c = '0;
    vsum_c = '0;
    for (int i = 0; i < N; i++) begin
      wsum_c = wsum_c + 18'(signed'({1'b0, norm[i]})) * 18'(signed'(6'(2*i - (N-1))));
      vsum_c = vsum_c + 14'(norm[i]);
    end
  end

  // centroid divider: |wsum|*128 / vsum
  logic [23:0] div_num, div_quo;
  logic        div_done, div_start;
  logic [17:0] wabs;
  assign wabs      = wsum_r[17] ? 18'(-wsum_r) : 18'(wsum_r);
  assign div_num   = {wabs[16:0], 7'd0};
  assign div_start = (state_r == ST_DIV);

  lscpd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_in  (div_num),
    .num_neg (wsum_r[17]),
    .den_in  (vsum_r),
    .done    (div_done),
    .quo     (div_quo)
  );

  // pid arithmetic helpers
  logic signed [23:0] quo_s;
  logic signed [15:0] integ_sum;
  logic signed [14:0] integ_c;
  logic signed [35:0] acc_div;
  logic signed [12:0] lsum, rsum;
  logic [9:0]         left_c, right_c;
  assign quo_s     = signed'(div_quo);
  assign integ_sum = 16'(integ_r) + 16'(pos_r);
  assign integ_c   = (integ_sum > 16'sd12800) ? 15'sd12800 :
                     (integ_sum < -16'sd12800) ? -15'sd12800 : 15'(integ_sum);
  // truncation toward zero of a division by 65536
  assign acc_div   = acc_r[35] ? -((-acc_r) >>> 16) : (acc_r >>> 16);
  assign lsum      = 13'(signed'({1'b0, base_r})) + 13'(drive_r);
  assign rsum      = 13'(signed'({1'b0, base_r})) - 13'(drive_r);
  assign left_c    = lsum[12] ? '0 : (lsum > 13'sd1023) ? 10'd1023 : lsum[9:0];
  assign right_c   = rsum[12] ? '0 : (rsum > 13'sd1023) ? 10'd1023 : rsum[9:0];

  // one multiply per cycle into the pid accumulator
  logic signed [16:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [32:0] mul_p;
  always_comb begin
    case (state_r)
      ST_MP:   begin mul_a = signed'({1'b0, gain_p_r}); mul_b = 16'(pos_r); end
      ST_MI:   begin mul_a = signed'({1'b0, gain_i_r}); mul_b = 16'(integ_r); end
      default: begin mul_a = signed'({1'b0, gain_d_r}); mul_b = 16'(deriv_r); end
    endcase
    mul_p = 33'(mul_a) * 33'(mul_b);
  end

  // control sequencer and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_p_r    <= 16'd6400;
      gain_i_r    <= 16'd0;
      gain_d_r    <= 16'd1280;
      base_r      <= 10'd90;
      prev_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (lscpd_pkg::reg_idx_t'(cfg_index))
          lscpd_pkg::REG_GAIN_P: gain_p_r <= cfg_data;
          lscpd_pkg::REG_GAIN_I: gain_i_r <= cfg_data;
          lscpd_pkg::REG_GAIN_D: gain_d_r <= cfg_data;
          lscpd_pkg::REG_BASE:   base_r   <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (cmd.start) state_r <= ST_NORM;
        ST_NORM: if (sts[0].done) state_r <= ST_SUM;
        ST_SUM: begin
          wsum_r  <= wsum_c;
          vsum_r  <= vsum_c;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          lost_r  <= (vsum_r == '0);
          state_r <= (vsum_r == '0) ? ST_POS : ST_DIVW;
        end
        ST_DIVW: if (div_done) state_r <= ST_POS;
        ST_POS: begin
          if (lost_r) pos_r <= prev_r;
          else if (quo_s > 24'sd896) pos_r <= 11'sd896;
          else if (quo_s < -24'sd896) pos_r <= -11'sd896;
          else pos_r <= 11'(quo_s);
          state_r <= ST_MP;
        end
        ST_MP: begin
          deriv_r <= 12'(pos_r) - 12'(prev_r);
          integ_r <= integ_c;
          prev_r  <= pos_r;
          acc_r   <= 36'(mul_p);
          state_r <= ST_MI;
        end
        ST_MI: begin
          acc_r   <= acc_r + 36'(mul_p);
          state_r <= ST_MD;
        end
        ST_MD: begin
          acc_r   <= acc_r + 36'(mul_p);
          state_r <= ST_DRV;
        end
        ST_DRV: begin
          drive_r <= (acc_div > 36'sd400) ? 10'sd400 :
                     (acc_div < -36'sd400) ? -10'sd400 : 10'(acc_div);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          out_data_r  <= {6'd0, lost_r, drive_r, pos_r, right_c, left_c};
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/lscpd_checker.sv]
// lscpd_checker: port-level assertions for the top level, bound to it
// depends on lscpd_pkg and line_sensor_centroid_pid_drive_unit
`timescale 1ns / 1ps
module lscpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no item taken while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready with result pending");

  // a non-step item never gives a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != lscpd_pkg::MODE_STEP && !out_tvalid
      |=> !out_tvalid)
    else $error("result from a non-step item");

  // drive within its limits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[40:31]) <= 10'sd400 &&
                    $signed(out_tdata[40:31]) >= -10'sd400))
    else $error("drive out of range");

endmodule

bind line_sensor_centroid_pid_drive_unit lscpd_checker u_lscpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
